/* sv/gwa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gwa_pkg;

    // fixed widths of the sample and result fields
    localparam int SAMPLE_W = 16;
    localparam int AVERAGE_W = 16;

    // 1/sqrt(2*pi) in q32
    localparam logic [127:0] INV_SQRT_2PI_Q32 = 128'd1713444047;

    // exp(-e) in q32 by a taylor series through the e^16 term, e in q32 below one
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] e);
        logic [127:0] ew;
        logic [127:0] t;
        logic [127:0] plus;
        logic [127:0] minus;
        begin
            ew = 128'(e);
            t = 128'd1 << 32;
            plus = t;
            minus = '0;
            t = ((t * ew) >> 32) / 1;  minus = minus + t;
            t = ((t * ew) >> 32) / 2;  plus = plus + t;
            t = ((t * ew) >> 32) / 3;  minus = minus + t;
            t = ((t * ew) >> 32) / 4;  plus = plus + t;
            t = ((t * ew) >> 32) / 5;  minus = minus + t;
            t = ((t * ew) >> 32) / 6;  plus = plus + t;
            t = ((t * ew) >> 32) / 7;  minus = minus + t;
            t = ((t * ew) >> 32) / 8;  plus = plus + t;
            t = ((t * ew) >> 32) / 9;  minus = minus + t;
            t = ((t * ew) >> 32) / 10; plus = plus + t;
            t = ((t * ew) >> 32) / 11; minus = minus + t;
            t = ((t * ew) >> 32) / 12; plus = plus + t;
            t = ((t * ew) >> 32) / 13; minus = minus + t;
            t = ((t * ew) >> 32) / 14; plus = plus + t;
            t = ((t * ew) >> 32) / 15; minus = minus + t;
            t = ((t * ew) >> 32) / 16; plus = plus + t;
            return 64'(plus - minus);
        end
    endfunction

endpackage

`default_nettype wire

/* sv/gwa_tap_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module gwa_tap_cell #(
    parameter int ACC_W = 42,
    parameter int WEIGHT_W = 24,
    parameter logic [WEIGHT_W-1:0] WEIGHT = '0
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                shift_en,
    input  wire logic signed [gwa_pkg::SAMPLE_W-1:0] sample,
    input  wire logic signed [ACC_W-1:0]             acc_in,
    output logic signed [ACC_W-1:0]                  acc_out
);

    localparam int PROD_W = gwa_pkg::SAMPLE_W + WEIGHT_W + 1;

    logic signed [WEIGHT_W:0]  weight_s;
    logic signed [PROD_W-1:0]  product;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    // tap product added to the partial sum from the neighbour cell
    assign weight_s = signed'({1'b0, WEIGHT});
    assign product  = PROD_W'(sample) * PROD_W'(weight_s);
    assign acc_next = acc_in + ACC_W'(product);

    // partial sum advances once per input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (shift_en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_out = acc_reg;

endmodule

`default_nettype wire

/* sv/gwa_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module gwa_out_stage #(
    parameter int ACC_W = 42,
    parameter int FRAC_W = 24
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  load_en,
    input  wire logic signed [ACC_W-1:0]               acc,
    input  wire logic                                  m_ready,
    output logic                                       m_valid,
    output logic signed [gwa_pkg::AVERAGE_W-1:0]       m_average,
    output logic                                       in_ready
);

    localparam int RW = ACC_W + 1;
    localparam logic signed [RW-1:0] HALF_LSB = RW'(1) <<< (FRAC_W - 1);
    localparam logic signed [RW-1:0] MAX_OUT = RW'(32767);
    localparam logic signed [RW-1:0] MIN_OUT = -RW'(32768);

    logic signed [RW-1:0]                     rounded;
    logic signed [RW-1:0]                     scaled;
    logic signed [gwa_pkg::AVERAGE_W-1:0]     sat;
    logic                                     m_valid_reg;
    logic                                     m_valid_next;
    logic signed [gwa_pkg::AVERAGE_W-1:0]     m_average_reg;

    // round half up, drop fraction bits, clamp to the result range
    always_comb begin
        rounded = RW'(acc) + HALF_LSB;
        scaled  = rounded >>> FRAC_W;
        if (scaled > MAX_OUT) begin
            sat = 16'sh7fff;
        end else if (scaled < MIN_OUT) begin
            sat = -16'sh8000;
        end else begin
            sat = scaled[gwa_pkg::AVERAGE_W-1:0];
        end
    end

    // output register frees as soon as the held result is taken
    assign in_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load_en) begin
            m_average_reg <= sat;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_average = m_average_reg;

endmodule

`default_nettype wire

/* sv/gaussian_window_average_core.sv */
// gaussian weighted average over the previous TAPS samples, transposed tap chain
// the result is registered and valid in the cycle after the input transfer
// throughput: one sample per cycle unless stalled, set by one update per tap cell
// a new sample is taken while the output register is empty or being drained
// reset: synchronous active-low aresetn clears all partial sums (store of zeros)
// and the output valid
`timescale 1ns / 1ps
`default_nettype none

module gaussian_window_average_core #(
    parameter int TAPS = 200,
    parameter int WEIGHT_FRAC_BITS = 24
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [gwa_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed [gwa_pkg::AVERAGE_W-1:0]       m_average
);

    localparam int ACC_W = WEIGHT_FRAC_BITS + 18;
    localparam int HALF_TAPS = TAPS / 2;
    localparam logic [127:0] DEN_Q = 128'(8 * HALF_TAPS * HALF_TAPS);

    // weight of tap k (oldest sample at tap zero), fraction bits WEIGHT_FRAC_BITS
    function automatic logic [127:0] tap_weight(input int k);
        longint       d;
        logic [127:0] dd;
        logic [127:0] e;
        logic [127:0] x;
        logic [127:0] g;
        logic [127:0] q;
        begin
            d  = 2 * longint'(k) - 2 * longint'(HALF_TAPS) + 1;
            dd = 128'(d * d);
            e  = (dd << 32) / DEN_Q;
            x  = 128'(gwa_pkg::exp_neg_q32(e[63:0]));
            g  = (x * gwa_pkg::INV_SQRT_2PI_Q32) >> 32;
            q  = (g << WEIGHT_FRAC_BITS) / HALF_TAPS;
            return (q + (128'd1 << 31)) >> 32;
        end
    endfunction

    logic                     s_fire;
    logic signed [ACC_W-1:0]  chain [TAPS+1];

    assign s_fire = s_valid && s_ready;

    // far end of the chain feeds zero
    assign chain[TAPS] = '0;

    // cell c holds the weight for the sample c+1 transfers old
    for (genvar c = 0; c < TAPS; c++) begin : g_cell
        localparam logic [WEIGHT_FRAC_BITS-1:0] CELL_WEIGHT =
            WEIGHT_FRAC_BITS'(tap_weight(TAPS - 1 - c));

        gwa_tap_cell #(
            .ACC_W    (ACC_W),
            .WEIGHT_W (WEIGHT_FRAC_BITS),
            .WEIGHT   (CELL_WEIGHT)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (s_fire),
            .sample   (s_sample),
            .acc_in   (chain[c+1]),
            .acc_out  (chain[c])
        );
    end

    // head of the chain holds the sum over the stored window
    gwa_out_stage #(
        .ACC_W  (ACC_W),
        .FRAC_W (WEIGHT_FRAC_BITS)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_en   (s_fire),
        .acc       (chain[0]),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_average (m_average),
        .in_ready  (s_ready)
    );

endmodule

`default_nettype wire

/* sv/gwa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module gwa_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic signed [gwa_pkg::SAMPLE_W-1:0] s_sample,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic signed [gwa_pkg::AVERAGE_W-1:0] m_average
);

    // every input transfer gives a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result after input transfer");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average))
        else $error("stalled result changed");

    // input is taken whenever the output register can move
    a_ready_rule: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> s_ready == (!m_valid || m_ready))
        else $error("input ready does not follow output register");

    // a result taken with no new input leaves nothing behind
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !(s_valid && s_ready) |=> !m_valid)
        else $error("result repeated");

    // reset empties the output
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind gaussian_window_average_core gwa_checker u_checker (.*);

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int TAPS = 200;
    localparam int FRAC_BITS = 24;
    localparam longint unsigned INV_ROOT_TWO_PI = 64'd1713444047;
    localparam int SERIES_TERMS = 16;
    localparam int RAND_ITEMS = 1850;
    localparam int HOLD_AT = 1000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_DIR = 20;

    typedef logic signed [gwa_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic signed [gwa_pkg::AVERAGE_W-1:0] average_t;

    typedef struct {
        sample_t  smp;
        bit       known;
        average_t avg;
    } dir_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sample_t  s_sample = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    average_t m_average;

    // known result riding alongside the payload, sampled at the transfer edge
    logic     row_known = 1'b0;
    average_t row_avg = '0;

    gaussian_window_average_core #(
        .TAPS(TAPS),
        .WEIGHT_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_sample(s_sample),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_average(m_average)
    );

    always #5 aclk = ~aclk;

    // filter state mirrored in the bench
    longint   gauss_weight [TAPS];
    sample_t  hist_sample [TAPS];
    int       hist_pos;
    average_t average_due [$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    bit       held_off = 1'b0;

    // directed rows: only the first result after reset is read off directly
    dir_row_t dir_rows [NUM_DIR] = '{
        '{16'sh7fff, 1'b1, 16'sd0},
        '{16'sh8000, 1'b0, 16'sd0},
        '{16'sh0000, 1'b0, 16'sd0},
        '{16'shffff, 1'b0, 16'sd0},
        '{16'sh0001, 1'b0, 16'sd0},
        '{16'sh5555, 1'b0, 16'sd0},
        '{16'shaaaa, 1'b0, 16'sd0},
        '{16'sh7fff, 1'b0, 16'sd0},
        '{16'sh7fff, 1'b0, 16'sd0},
        '{16'sh8000, 1'b0, 16'sd0},
        '{16'sh8000, 1'b0, 16'sd0},
        '{16'sh0100, 1'b0, 16'sd0},
        '{16'shff00, 1'b0, 16'sd0},
        '{16'sh0001, 1'b0, 16'sd0},
        '{16'shffff, 1'b0, 16'sd0},
        '{16'sh7ffe, 1'b0, 16'sd0},
        '{16'sh8001, 1'b0, 16'sd0},
        '{16'sh3039, 1'b0, 16'sd0},
        '{16'shcfc7, 1'b0, 16'sd0},
        '{16'sh0000, 1'b0, 16'sd0}
    };

    // exp(-e) in q32, alternating taylor series with truncated terms
    function automatic longint unsigned decay_q32(input longint unsigned e);
        longint unsigned term;
        longint unsigned pos;
        longint unsigned neg;
        term = 64'd1 << 32;
        pos = term;
        neg = 0;
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * e) >> 32) / 64'(n);
            if (n % 2 == 1)
                neg += term;
            else
                pos += term;
        end
        return pos - neg;
    endfunction

    // tap weights in q24, bell centred between the two middle taps
    function automatic void build_gauss_weights();
        longint unsigned sig;
        longint unsigned dd;
        longint unsigned ex;
        longint unsigned bell;
        longint unsigned q;
        longint offs;
        sig = 64'(TAPS / 2);
        for (int k = 0; k < TAPS; k++) begin
            offs = 2 * longint'(k) - 2 * longint'(sig) + 1;
            dd = 64'(offs * offs);
            ex = (dd << 32) / (8 * sig * sig);
            bell = (decay_q32(ex) * INV_ROOT_TWO_PI) >> 32;
            q = (bell << FRAC_BITS) / sig;
            gauss_weight[k] = longint'((q + (64'd1 << 31)) >> 32);
        end
    endfunction

    // weighted sum over the history, oldest first, then the new sample overwrites it
    function automatic average_t weighted_average(input sample_t smp);
        longint acc;
        longint res;
        int idx;
        acc = 0;
        idx = hist_pos;
        for (int i = 0; i < TAPS; i++) begin
            acc += longint'(hist_sample[idx]) * gauss_weight[i];
            idx = (idx == TAPS - 1) ? 0 : idx + 1;
        end
        res = (acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (res > 32767)
            res = 32767;
        if (res < -32768)
            res = -32768;
        hist_sample[hist_pos] = smp;
        hist_pos = (hist_pos == TAPS - 1) ? 0 : hist_pos + 1;
        return average_t'(res);
    endfunction

    task automatic flag_mismatch(input string what, input average_t got, input average_t want);
        $display("mismatch at cycle %0d: %s, got %0d, want %0d",
                 cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // offer one sample, idling between bursts, and wait for its transfer
    task automatic send_sample(input sample_t v, input bit known, input average_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_sample <= v;
        row_known <= known;
        row_avg <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // cycle count and timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // input transfers feed the predictor, output transfers are checked in order
    always @(posedge aclk) begin
        average_t pred;
        average_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                pred = weighted_average(s_sample);
                average_due.push_back(row_known ? row_avg : pred);
            end
            if (m_valid && m_ready) begin
                if (average_due.size() == 0) begin
                    flag_mismatch("result with none outstanding", m_average, '0);
                end else begin
                    want = average_due.pop_front();
                    if (m_average !== want)
                        flag_mismatch("average", m_average, want);
                end
            end
        end
    end

    // receiver back-pressure, with one long hold-off to fill the block
    initial begin : receiver
        int mode;
        int len;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held_off && cycle_count >= HOLD_AT) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            len = $urandom_range(10, 80);
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (k % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // reset, directed rows, random segments, drain
    initial begin : stimulus
        int sent;
        int kind;
        int seg_len;
        sample_t v;
        sample_t walk;
        sample_t run_val;
        build_gauss_weights();
        for (int i = 0; i < TAPS; i++)
            hist_sample[i] = '0;
        hist_pos = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_DIR; r++)
            send_sample(dir_rows[r].smp, dir_rows[r].known, dir_rows[r].avg);

        sent = 0;
        walk = '0;
        while (sent < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            seg_len = (kind == 4) ? $urandom_range(200, 240) : $urandom_range(20, 120);
            run_val = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            for (int j = 0; j < seg_len && sent < RAND_ITEMS; j++) begin
                case (kind)
                    // full window of one extreme drives the average to its largest magnitude
                    4: v = run_val;
                    5: v = sample_t'(int'($urandom_range(0, 128)) - 64);
                    6: v = (j % 2 == 0) ? 16'sh7fff : 16'sh8000;
                    7: begin
                        walk = walk + sample_t'(int'($urandom_range(0, 2048)) - 1024);
                        v = walk;
                    end
                    8: v = $urandom_range(0, 3) == 0 ? run_val : sample_t'($urandom);
                    default: v = sample_t'($urandom);
                endcase
                send_sample(v, 1'b0, '0);
                sent++;
            end
        end
        s_valid <= 1'b0;
        row_known <= 1'b0;
        @(posedge aclk);

        while (average_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
